// ----- src/tldc_pkg.sv -----
// Shared types, constants and float decode for the transmission loss converter.
`default_nettype none
package tldc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_SUM, ST_NORM, ST_STEP, ST_STORE,
    ST_LOSS, ST_ACC, ST_DIVI, ST_DIV, ST_EMIT
  } ctl_state_e;

  typedef enum logic [1:0] {SRC_P, SRC_MIN, SRC_REF} src_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_SQA, OP_SQB, OP_SUM, OP_NORM, OP_STEP, OP_STORE,
    OP_LOSS, OP_ACC, OP_DIVI, OP_DIV, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic   capture;
    dp_op_e op;
    src_e   src;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]        cls;
    logic [23:0]       man;
    logic signed [8:0] exp;
  } fp_t;

  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_FIN  = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  localparam logic [1:0] REG_REF = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_NSL = 2'd2;

  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned DIV_STEPS = 49;

  localparam logic signed [26:0] DB_PER_LOG2 = 27'sd50504453;
  localparam logic signed [18:0] LOSS_MAX = 19'sh3FFFF;
  localparam logic signed [18:0] LOSS_MIN = 19'sh40000;

  function automatic fp_t fdecode(input logic [31:0] b);
    fp_t        r;
    logic [7:0] ex;
    logic [22:0] fr;
    ex = b[30:23];
    fr = b[22:0];
    r.man = 24'd0;
    r.exp = 9'sd0;
    if (ex == 8'hFF) begin
      r.cls = (fr != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (ex == 8'd0) begin
      if (fr == 23'd0) begin
        r.cls = CLS_ZERO;
      end else begin
        r.cls = CLS_FIN;
        r.man = {1'b0, fr};
        r.exp = -9'sd149;
      end
    end else begin
      r.cls = CLS_FIN;
      r.man = {1'b1, fr};
      r.exp = 9'($signed({2'b00, ex}) - 10'sd150);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/tldc_ctrl.sv -----
// Sequencer for the converter: handshakes and step control of the datapath.
`default_nettype none
module tldc_ctrl import tldc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctl_state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  src_e       src_q, src_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 6'd0;
      src_q       <= SRC_P;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    src_d   = src_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SQA;
          src_d   = SRC_P;
        end
      end
      ST_SQA:  state_d = ST_SQB;
      ST_SQB:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_NORM;
      ST_NORM: begin
        if (stat_i.norm_done) begin
          state_d = ST_STEP;
          cnt_d   = 6'd0;
        end
      end
      ST_STEP: begin
        if (cnt_q == 6'(LOG_STEPS - 1)) state_d = ST_STORE;
        else cnt_d = cnt_q + 6'd1;
      end
      ST_STORE: begin
        case (src_q)
          SRC_P:   begin src_d = SRC_MIN; state_d = ST_SQA; end
          SRC_MIN: begin src_d = SRC_REF; state_d = ST_SQA; end
          default: state_d = ST_LOSS;
        endcase
      end
      ST_LOSS: state_d = ST_ACC;
      ST_ACC:  state_d = ST_DIVI;
      ST_DIVI: begin
        state_d = ST_DIV;
        cnt_d   = 6'd0;
      end
      ST_DIV: begin
        if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_EMIT;
        else cnt_d = cnt_q + 6'd1;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.src     = src_q;
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ST_SQA:   cmd_o.op = OP_SQA;
      ST_SQB:   cmd_o.op = OP_SQB;
      ST_SUM:   cmd_o.op = OP_SUM;
      ST_NORM:  cmd_o.op = OP_NORM;
      ST_STEP:  cmd_o.op = OP_STEP;
      ST_STORE: cmd_o.op = OP_STORE;
      ST_LOSS:  cmd_o.op = OP_LOSS;
      ST_ACC:   cmd_o.op = OP_ACC;
      ST_DIVI:  cmd_o.op = OP_DIVI;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_EMIT: begin
        cmd_o.op = slot_free ? OP_EMIT : OP_NONE;
        if (slot_free) out_valid_d = 1'b1;
      end
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/tldc_datapath.sv -----
// Datapath: config registers, log2 unit, loss scaling, accumulator and divider.
`default_nettype none
module tldc_datapath import tldc_pkg::*; #(
  parameter int unsigned MAX_RECEIVERS = 1048576
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [31:0]        pressure_real_i,
  input  wire logic [31:0]        pressure_imag_i,
  input  wire logic               last_receiver_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  output logic signed [18:0]      loss_db_o,
  output logic                    loss_valid_o,
  output logic signed [18:0]      average_loss_o,
  output logic                    average_ready_o
);

  localparam int unsigned CountFull = 2097151;
  localparam logic [20:0] CountCap =
    21'((MAX_RECEIVERS < CountFull) ? MAX_RECEIVERS : CountFull);

  logic [31:0]        ref_q, min_q;
  logic signed [18:0] nsl_q;
  logic signed [47:0] sum_q;
  logic [20:0]        cnt_q;

  logic [31:0]        re_q, im_q;
  logic               last_q;
  logic [47:0]        sqa_q, sqb_q;
  logic [48:0]        s_q;
  logic [5:0]         shcnt_q;
  logic [30:0]        x_q;
  logic [15:0]        frac_q;
  logic signed [25:0] lp_q, lmin_q, lref_q;
  logic signed [26:0] d_q;
  logic signed [54:0] lprod_q;
  logic signed [18:0] loss_q;
  logic               lvalid_q;
  logic [48:0]        n_q;
  logic [20:0]        dv_q, r_q;
  logic               neg_q, avg_ok_q;
  logic signed [18:0] out_loss_q, out_avg_q;
  logic               out_lvalid_q, out_last_q;

  fp_t                dr, di, dm, dref, fa, fb;
  logic               ha, hb, hsel;
  logic signed [8:0]  big;
  logic signed [9:0]  diff_a, diff_b, dsel;
  logic [31:0]        mul_x;
  logic [63:0]        prod;
  logic [47:0]        term;
  logic [31:0]        y;
  logic signed [9:0]  ipart;
  logic signed [25:0] lval;
  logic signed [26:0] dval;
  logic signed [27:0] nd;
  logic signed [54:0] rnd;
  logic signed [22:0] raw;
  logic signed [18:0] sat, loss_res;
  logic               zero, nosig, lvalid, norm_done;
  logic [47:0]        abs_sum;
  logic [21:0]        rt;
  logic [18:0]        avg;

  always_comb begin
    dr   = fdecode(re_q);
    di   = fdecode(im_q);
    dm   = fdecode(min_q);
    dref = fdecode(ref_q);
    case (cmd_i.src)
      SRC_P: begin
        fa = dr; fb = di;
        ha = (dr.cls == CLS_FIN); hb = (di.cls == CLS_FIN);
      end
      SRC_MIN: begin
        fa = dm; fb = dm;
        ha = (dm.cls == CLS_FIN); hb = 1'b0;
      end
      default: begin
        fa = dref; fb = dref;
        ha = (dref.cls == CLS_FIN); hb = 1'b0;
      end
    endcase
    if (ha && hb) big = (fa.exp > fb.exp) ? fa.exp : fb.exp;
    else if (ha) big = fa.exp;
    else big = fb.exp;
    diff_a = 10'(big) - 10'(fa.exp);
    diff_b = 10'(big) - 10'(fb.exp);
    dsel   = (cmd_i.op == OP_SQB) ? diff_b : diff_a;
    hsel   = (cmd_i.op == OP_SQB) ? hb : ha;
    case (cmd_i.op)
      OP_SQA:  mul_x = {8'd0, fa.man};
      OP_SQB:  mul_x = {8'd0, fb.man};
      default: mul_x = {1'b0, x_q};
    endcase
    prod = {32'd0, mul_x} * {32'd0, mul_x};
    term = (!hsel || dsel >= 10'sd24) ? 48'd0 : (prod[47:0] >> {dsel[4:0], 1'b0});
    y    = prod[61:30];
    norm_done = s_q[48] || (s_q == 49'd0);
    ipart = $signed({4'd0, 6'd48 - shcnt_q}) + $signed({big, 1'b0});
    lval  = {ipart, frac_q};
    dval  = 27'(lp_q) - 27'(lref_q);
    nd    = -28'(dval);
  end

  assign stat_o.norm_done = norm_done;

  always_comb begin
    rnd  = lprod_q + (55'sd1 <<< 31);
    raw  = rnd[54:32];
    if (raw > 23'sd262143) sat = LOSS_MAX;
    else if (raw < -23'sd262144) sat = LOSS_MIN;
    else sat = raw[18:0];
    zero  = (dr.cls == CLS_ZERO) && (di.cls == CLS_ZERO);
    nosig = (dr.cls == CLS_INF) || (dr.cls == CLS_NAN) ||
            (di.cls == CLS_INF) || (di.cls == CLS_NAN) ||
            (!min_q[31] && ((dm.cls == CLS_INF) ||
                            ((dm.cls == CLS_FIN) && (zero || (lp_q < lmin_q))))) ||
            ref_q[31] || (dref.cls != CLS_FIN) || zero ||
            (d_q >= 27'sd16777216) || (d_q < -27'sd19529728);
    loss_res = nosig ? nsl_q : sat;
    lvalid   = (20'(loss_res) < (20'(nsl_q) - 20'sd256));
    abs_sum  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
    rt       = {r_q, n_q[48]};
    if (!avg_ok_q) avg = 19'd0;
    else if (neg_q) avg = (n_q > 49'd262144) ? LOSS_MIN : 19'(-n_q[18:0]);
    else avg = (n_q > 49'd262143) ? LOSS_MAX : n_q[18:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 32'h3F80_0000;
      min_q <= 32'd0;
      nsl_q <= 19'sd0;
      sum_q <= 48'sd0;
      cnt_q <= 21'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REF: ref_q <= cfg_data_i;
          REG_MIN: min_q <= cfg_data_i;
          REG_NSL: nsl_q <= cfg_data_i[18:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC && lvalid && cnt_q < CountCap) begin
        sum_q <= sum_q + 48'(loss_res);
        cnt_q <= cnt_q + 21'd1;
      end
      if (cmd_i.op == OP_DIVI && last_q) begin
        sum_q <= 48'sd0;
        cnt_q <= 21'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      re_q   <= pressure_real_i;
      im_q   <= pressure_imag_i;
      last_q <= last_receiver_i;
    end
    case (cmd_i.op)
      OP_SQA: sqa_q <= term;
      OP_SQB: sqb_q <= term;
      OP_SUM: begin
        s_q     <= {1'b0, sqa_q} + {1'b0, sqb_q};
        shcnt_q <= 6'd0;
        frac_q  <= 16'd0;
      end
      OP_NORM: begin
        if (norm_done) begin
          x_q <= s_q[48:18];
        end else if (s_q[48:41] == 8'd0) begin
          s_q     <= {s_q[40:0], 8'd0};
          shcnt_q <= shcnt_q + 6'd8;
        end else begin
          s_q     <= {s_q[47:0], 1'b0};
          shcnt_q <= shcnt_q + 6'd1;
        end
      end
      OP_STEP: begin
        if (y[31]) begin
          x_q    <= y[31:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          x_q    <= y[30:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      OP_STORE: begin
        case (cmd_i.src)
          SRC_P:   lp_q   <= lval;
          SRC_MIN: lmin_q <= lval;
          default: lref_q <= lval;
        endcase
      end
      OP_LOSS: begin
        d_q     <= dval;
        lprod_q <= 55'(nd) * 55'(DB_PER_LOG2);
      end
      OP_ACC: begin
        loss_q   <= loss_res;
        lvalid_q <= lvalid;
      end
      OP_DIVI: begin
        n_q      <= {1'b0, abs_sum} + 49'(cnt_q >> 1);
        dv_q     <= cnt_q;
        r_q      <= 21'd0;
        neg_q    <= sum_q[47];
        avg_ok_q <= last_q && (cnt_q != 21'd0);
      end
      OP_DIV: begin
        if (rt >= {1'b0, dv_q}) begin
          r_q <= 21'(rt - {1'b0, dv_q});
          n_q <= {n_q[47:0], 1'b1};
        end else begin
          r_q <= rt[20:0];
          n_q <= {n_q[47:0], 1'b0};
        end
      end
      OP_EMIT: begin
        out_loss_q   <= loss_q;
        out_lvalid_q <= lvalid_q;
        out_avg_q    <= avg;
        out_last_q   <= last_q;
      end
      default: ;
    endcase
  end

  assign loss_db_o       = out_loss_q;
  assign loss_valid_o    = out_lvalid_q;
  assign average_loss_o  = out_avg_q;
  assign average_ready_o = out_last_q;

endmodule
`default_nettype wire

// ----- src/transmission_loss_db_converter.sv -----
// Top level of the complex pressure to transmission loss converter.
//
// Input channel: in_valid_i / in_stall_o carry one word per receiver: the IEEE
// single real and imaginary parts and the last-receiver flag.
// Output channel: out_valid_o / out_stall_i carry one result word per input:
// loss in 1/256 dB, its valid flag, and on the last receiver the field average.
// Config channel: cfg_valid_i / cfg_ready_o write reference pressure (0),
// minimum magnitude (1) and no-signal level (2); cfg_ready_o is always high.
// Each accepted word goes through three passes of one shared log2 unit
// (normalize, then 16 squaring steps) for the pressure, the minimum and the
// reference, then scaling, accumulation and a bit-serial divider for the
// average, emitting the result once the output slot is free. One word is in
// work at a time; a finished result sits in the output register so the next
// word is taken while the receiver stalls. A stalled result holds until
// taken, and the next result waits behind it.
// Reset clears the sum, count and config registers to defaults, no clearing pass.
`default_nettype none
module transmission_loss_db_converter import tldc_pkg::*; #(
  parameter int unsigned MAX_RECEIVERS = 1048576
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [31:0]        pressure_real_i,
  input  wire logic [31:0]        pressure_imag_i,
  input  wire logic               last_receiver_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [18:0]      loss_db_o,
  output logic                    loss_valid_o,
  output logic signed [18:0]      average_loss_o,
  output logic                    average_ready_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tldc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tldc_datapath #(
    .MAX_RECEIVERS (MAX_RECEIVERS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pressure_real_i (pressure_real_i),
    .pressure_imag_i (pressure_imag_i),
    .last_receiver_i (last_receiver_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .loss_db_o       (loss_db_o),
    .loss_valid_o    (loss_valid_o),
    .average_loss_o  (average_loss_o),
    .average_ready_o (average_ready_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("converter not busy after accepting a word");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !average_ready_o) |-> (average_loss_o == 19'sd0))
    else $error("average nonzero on a non-last word");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule
`default_nettype wire
